FILE: sv/acd_pkg.sv
// Shared types, byte codes and the SGR update function of the CSI command decoder.
`default_nettype none

package acd_pkg;

   // Result field widths
   localparam int COORD_BITS = 14;
   localparam int DELTA_BITS = 15;
   localparam logic [COORD_BITS-1:0] COORD_MAX = 14'h3FFF;
   // Widest parameter value handed to the SGR decode
   localparam int SGR_ARG_BITS = 16;
   // Command queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // Byte codes
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_CUU      = 8'h41;
   localparam logic [7:0] CH_CUD      = 8'h42;
   localparam logic [7:0] CH_CUF      = 8'h43;
   localparam logic [7:0] CH_CUB      = 8'h44;
   localparam logic [7:0] CH_CUP      = 8'h48;
   localparam logic [7:0] CH_ED       = 8'h4A;
   localparam logic [7:0] CH_EL       = 8'h4B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_HVP      = 8'h66;
   localparam logic [7:0] CH_SGR      = 8'h6D;
   localparam logic [7:0] CH_FINAL_HI = 8'h7E;

   // SGR codes
   localparam logic [SGR_ARG_BITS-1:0] SGR_RESET        = 16'd0;
   localparam logic [SGR_ARG_BITS-1:0] SGR_BOLD         = 16'd1;
   localparam logic [SGR_ARG_BITS-1:0] SGR_FAINT        = 16'd2;
   localparam logic [SGR_ARG_BITS-1:0] SGR_ITALIC       = 16'd3;
   localparam logic [SGR_ARG_BITS-1:0] SGR_UNDERLINE    = 16'd4;
   localparam logic [SGR_ARG_BITS-1:0] SGR_INVERSE      = 16'd7;
   localparam logic [SGR_ARG_BITS-1:0] SGR_NORMAL       = 16'd22;
   localparam logic [SGR_ARG_BITS-1:0] SGR_NO_ITALIC    = 16'd23;
   localparam logic [SGR_ARG_BITS-1:0] SGR_NO_UNDERLINE = 16'd24;
   localparam logic [SGR_ARG_BITS-1:0] SGR_NO_INVERSE   = 16'd27;
   localparam logic [SGR_ARG_BITS-1:0] SGR_FG_FIRST     = 16'd30;
   localparam logic [SGR_ARG_BITS-1:0] SGR_FG_LAST      = 16'd37;
   localparam logic [SGR_ARG_BITS-1:0] SGR_FG_DEFAULT   = 16'd39;
   localparam logic [SGR_ARG_BITS-1:0] SGR_BG_FIRST     = 16'd40;
   localparam logic [SGR_ARG_BITS-1:0] SGR_BG_LAST      = 16'd47;
   localparam logic [SGR_ARG_BITS-1:0] SGR_BG_DEFAULT   = 16'd49;
   // Offsets from SGR color code to color index (1 = black)
   localparam logic [SGR_ARG_BITS-1:0] SGR_FG_BIAS      = 16'd29;
   localparam logic [SGR_ARG_BITS-1:0] SGR_BG_BIAS      = 16'd39;

   // Style flag bits
   localparam int FLAG_BOLD      = 0;
   localparam int FLAG_FAINT     = 1;
   localparam int FLAG_ITALIC    = 2;
   localparam int FLAG_UNDERLINE = 3;
   localparam int FLAG_INVERSE   = 4;

   typedef enum logic [3:0] {
      OP_PUT_CHAR  = 4'd0,
      OP_CR        = 4'd1,
      OP_LF        = 4'd2,
      OP_BACKSPACE = 4'd3,
      OP_MOVE_REL  = 4'd4,
      OP_MOVE_ABS  = 4'd5,
      OP_ERASE_DSP = 4'd6,
      OP_ERASE_LN  = 4'd7,
      OP_SET_ATTR  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef struct packed {
      logic [3:0] bg;
      logic [3:0] fg;
      logic [4:0] flags;
   } attrs_type;

   // One classified command from front to back
   typedef struct packed {
      op_type                op;
      logic [7:0]            char_code;
      dir_type               dir;
      logic [COORD_BITS-1:0] p0;   // first parameter, clamped
      logic [COORD_BITS-1:0] p1;   // second parameter, clamped
      attrs_type             attrs;
   } cmd_type;

   // Apply one SGR parameter to the running attributes
   function automatic attrs_type sgr_apply(input attrs_type a, input logic [SGR_ARG_BITS-1:0] p);
      attrs_type r;
      r = a;
      priority if (p == SGR_RESET) begin
         r = '0;
      end else if (p == SGR_BOLD) begin
         r.flags[FLAG_BOLD] = 1'b1;
      end else if (p == SGR_FAINT) begin
         r.flags[FLAG_FAINT] = 1'b1;
      end else if (p == SGR_ITALIC) begin
         r.flags[FLAG_ITALIC] = 1'b1;
      end else if (p == SGR_UNDERLINE) begin
         r.flags[FLAG_UNDERLINE] = 1'b1;
      end else if (p == SGR_INVERSE) begin
         r.flags[FLAG_INVERSE] = 1'b1;
      end else if (p == SGR_NORMAL) begin
         r.flags[FLAG_BOLD]  = 1'b0;
         r.flags[FLAG_FAINT] = 1'b0;
      end else if (p == SGR_NO_ITALIC) begin
         r.flags[FLAG_ITALIC] = 1'b0;
      end else if (p == SGR_NO_UNDERLINE) begin
         r.flags[FLAG_UNDERLINE] = 1'b0;
      end else if (p == SGR_NO_INVERSE) begin
         r.flags[FLAG_INVERSE] = 1'b0;
      end else if (p == SGR_FG_DEFAULT) begin
         r.fg = 4'd0;
      end else if (p == SGR_BG_DEFAULT) begin
         r.bg = 4'd0;
      end else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) begin
         r.fg = 4'(p - SGR_FG_BIAS);
      end else if (p >= SGR_BG_FIRST && p <= SGR_BG_LAST) begin
         r.bg = 4'(p - SGR_BG_BIAS);
      end else begin
         r = a;   // unknown code leaves attributes alone
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/acd_stream_ifs.sv
// Valid/ready channel interfaces for the byte input and the command output.
`default_nettype none

interface acd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface acd_rsp_if import acd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [3:0]                   op;
   logic [7:0]                   char_code;
   logic signed [DELTA_BITS-1:0] delta_col;
   logic signed [DELTA_BITS-1:0] delta_row;
   logic [COORD_BITS-1:0]        abs_col;
   logic [COORD_BITS-1:0]        abs_row;
   logic [4:0]                   style_flags;
   logic [3:0]                   fg_color;
   logic [3:0]                   bg_color;

   modport source (output valid, output op, output char_code, output delta_col,
                   output delta_row, output abs_col, output abs_row,
                   output style_flags, output fg_color, output bg_color,
                   input ready);
   modport sink   (input valid, input op, input char_code, input delta_col,
                   input delta_row, input abs_col, input abs_row,
                   input style_flags, input fg_color, input bg_color,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/ansi_csi_command_decoder_core.sv
// Top level of the ANSI CSI command decoder: parser front, command queue, result back.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    in_byte (8)
//   rsp_chan   out   valid/ready    op, char_code, delta_col/row, abs_col/row,
//                                   style_flags, fg_color, bg_color
//
// One byte is taken every cycle while the queue is not full; a byte that yields
// a command is written into the queue when it is accepted and from there loaded
// into the output register that drives rsp_chan.
// The parser state lives in the front; numbers accumulate one digit per byte.
// Synchronous reset returns the parser to ground and empties queue and output.
// A stalled rsp_chan fills the two-entry queue; req_chan.ready drops only when
// it is full.
`default_nettype none

module ansi_csi_command_decoder_core import acd_pkg::*; #(
   parameter int PARAM_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   acd_req_if.sink   req_chan,
   acd_rsp_if.source rsp_chan
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   acd_front #(
      .PARAM_BITS (PARAM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full)
   );

   acd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .pop      (q_pop)
   );

   acd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: sv/acd_front.sv
// Front end: byte parser state machine, parameter accumulation and command classification.
`default_nettype none

module acd_front import acd_pkg::*; #(
   parameter int PARAM_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   acd_req_if.sink   req_chan,
   output logic      push_valid,
   output cmd_type   push_cmd,
   input  wire logic q_full
);

   localparam int ACC_BITS = PARAM_BITS + 4;
   localparam int WIDE_BITS = (PARAM_BITS > COORD_BITS) ? PARAM_BITS : COORD_BITS;
   localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_GROUND = 3'b001,
      PH_ESCAPE = 3'b010,
      PH_CSI    = 3'b100
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [PARAM_BITS-1:0] accum_ff, accum_in;
   logic                  nonempty_ff, nonempty_in;
   logic [1:0]            idx_ff, idx_in;
   logic [PARAM_BITS-1:0] first_ff, first_in;
   logic [PARAM_BITS-1:0] second_ff, second_in;
   attrs_type             attrs_ff, attrs_in;

   logic                  accept;
   logic [7:0]            b;
   logic                  is_final;
   logic                  is_digit;
   logic [ACC_BITS-1:0]   digit_val;
   logic [PARAM_BITS-1:0] digit_sat;
   attrs_type             close_attrs;
   logic [1:0]            close_idx;
   logic [PARAM_BITS-1:0] close_first;
   logic [PARAM_BITS-1:0] close_second;
   logic [PARAM_BITS-1:0] fin_first;
   logic [PARAM_BITS-1:0] fin_second;
   attrs_type             fin_attrs;
   logic [WIDE_BITS-1:0]  first_wide;
   logic [WIDE_BITS-1:0]  second_wide;
   logic [COORD_BITS-1:0] p0_clamp;
   logic [COORD_BITS-1:0] p1_clamp;

   assign b = req_chan.in_byte;
   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;

   // Byte classes
   assign is_final = (b >= CH_FINAL_LO) && (b <= CH_FINAL_HI);
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

   // Decimal accumulate with saturation
   assign digit_val = ACC_BITS'(accum_ff) * ACC_BITS'(10) + ACC_BITS'(b - CH_ZERO);
   assign digit_sat = (digit_val > ACC_BITS'(PARAM_MAX)) ? PARAM_MAX
                                                          : digit_val[PARAM_BITS-1:0];

   // Field close: apply SGR, latch first two parameters
   assign close_attrs  = sgr_apply(attrs_ff, SGR_ARG_BITS'(accum_ff));
   assign close_idx    = (idx_ff == 2'd3) ? 2'd3 : idx_ff + 2'd1;
   assign close_first  = (idx_ff == 2'd0) ? accum_ff : first_ff;
   assign close_second = (idx_ff == 2'd1) ? accum_ff : second_ff;

   // Values seen by a final byte (open field closes first)
   assign fin_first  = nonempty_ff ? close_first  : first_ff;
   assign fin_second = nonempty_ff ? close_second : second_ff;
   assign fin_attrs  = nonempty_ff ? close_attrs  : attrs_ff;

   // Clamp parameters to the coordinate range
   assign first_wide  = WIDE_BITS'(fin_first);
   assign second_wide = WIDE_BITS'(fin_second);
   assign p0_clamp = (first_wide > WIDE_BITS'(COORD_MAX)) ? COORD_MAX
                                                         : first_wide[COORD_BITS-1:0];
   assign p1_clamp = (second_wide > WIDE_BITS'(COORD_MAX)) ? COORD_MAX
                                                          : second_wide[COORD_BITS-1:0];

   // Next state and command generation
   always_comb begin
      phase_in    = phase_ff;
      accum_in    = accum_ff;
      nonempty_in = nonempty_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      attrs_in    = attrs_ff;
      push_valid  = 1'b0;
      push_cmd    = '0;
      push_cmd.p0    = p0_clamp;
      push_cmd.p1    = p1_clamp;
      push_cmd.attrs = fin_attrs;
      push_cmd.char_code = b;

      if (accept) begin
         unique case (phase_ff)
            PH_ESCAPE: begin
               if (b == CH_LBRACKET) begin
                  phase_in    = PH_CSI;
                  accum_in    = '0;
                  nonempty_in = 1'b0;
                  idx_in      = 2'd0;
                  first_in    = '0;
                  second_in   = '0;
                  attrs_in    = '0;
               end else begin
                  phase_in = PH_GROUND;
               end
            end
            PH_CSI: begin
               if (!is_final) begin
                  nonempty_in = 1'b1;
                  if (b == CH_SEMI) begin
                     attrs_in  = close_attrs;
                     first_in  = close_first;
                     second_in = close_second;
                     idx_in    = close_idx;
                     accum_in  = '0;
                  end else if (is_digit) begin
                     accum_in = digit_sat;
                  end
               end else begin
                  phase_in = PH_GROUND;
                  if (nonempty_ff) begin
                     attrs_in  = close_attrs;
                     first_in  = close_first;
                     second_in = close_second;
                     idx_in    = close_idx;
                     accum_in  = '0;
                  end
                  unique case (b)
                     CH_CUU: begin
                        push_valid   = 1'b1;
                        push_cmd.op  = OP_MOVE_REL;
                        push_cmd.dir = DIR_UP;
                     end
                     CH_CUD: begin
                        push_valid   = 1'b1;
                        push_cmd.op  = OP_MOVE_REL;
                        push_cmd.dir = DIR_DOWN;
                     end
                     CH_CUF: begin
                        push_valid   = 1'b1;
                        push_cmd.op  = OP_MOVE_REL;
                        push_cmd.dir = DIR_RIGHT;
                     end
                     CH_CUB: begin
                        push_valid   = 1'b1;
                        push_cmd.op  = OP_MOVE_REL;
                        push_cmd.dir = DIR_LEFT;
                     end
                     CH_CUP, CH_HVP: begin
                        push_valid  = 1'b1;
                        push_cmd.op = OP_MOVE_ABS;
                     end
                     CH_ED: begin
                        push_valid  = 1'b1;
                        push_cmd.op = OP_ERASE_DSP;
                     end
                     CH_EL: begin
                        push_valid  = 1'b1;
                        push_cmd.op = OP_ERASE_LN;
                     end
                     CH_SGR: begin
                        push_valid  = 1'b1;
                        push_cmd.op = OP_SET_ATTR;
                     end
                     default: push_valid = 1'b0;   // unknown final, no command
                  endcase
               end
            end
            PH_GROUND: begin
               priority if (b == CH_ESC) begin
                  phase_in = PH_ESCAPE;
               end else if (b == CH_CR) begin
                  push_valid  = 1'b1;
                  push_cmd.op = OP_CR;
               end else if (b == CH_LF) begin
                  push_valid  = 1'b1;
                  push_cmd.op = OP_LF;
               end else if (b == CH_BS) begin
                  push_valid  = 1'b1;
                  push_cmd.op = OP_BACKSPACE;
               end else if (b >= CH_PRINT_LO) begin
                  push_valid  = 1'b1;
                  push_cmd.op = OP_PUT_CHAR;
               end else begin
                  push_valid = 1'b0;   // other control bytes dropped
               end
            end
            default: phase_in = PH_GROUND;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_GROUND;
         accum_ff    <= '0;
         nonempty_ff <= 1'b0;
         idx_ff      <= 2'd0;
         first_ff    <= '0;
         second_ff   <= '0;
         attrs_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         nonempty_ff <= nonempty_in;
         idx_ff      <= idx_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         attrs_ff    <= attrs_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/acd_cmd_queue.sv
// Short command queue that decouples the parser front end from the result back end.
`default_nettype none

module acd_cmd_queue import acd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         q_valid,
   output cmd_type      q_cmd,
   input  wire logic    pop
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: sv/acd_back.sv
// Back end: turns queued commands into result fields and holds them in the output register.
`default_nettype none

module acd_back import acd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   acd_rsp_if.source    rsp_chan
);

   logic                         valid_ff;
   logic [3:0]                   op_ff, op_in;
   logic [7:0]                   char_ff, char_in;
   logic signed [DELTA_BITS-1:0] dcol_ff, dcol_in;
   logic signed [DELTA_BITS-1:0] drow_ff, drow_in;
   logic [COORD_BITS-1:0]        acol_ff, acol_in;
   logic [COORD_BITS-1:0]        arow_ff, arow_in;
   attrs_type                    attrs_ff, attrs_in;

   logic [COORD_BITS-1:0]        step;
   logic signed [DELTA_BITS-1:0] step_pos;
   logic signed [DELTA_BITS-1:0] step_neg;

   // Load when the output register is empty or being drained
   assign q_pop = q_valid && (!valid_ff || rsp_chan.ready);

   // A missing or zero count moves by one
   assign step     = (q_cmd.p0 == '0) ? COORD_BITS'(1) : q_cmd.p0;
   assign step_pos = signed'({1'b0, step});
   assign step_neg = -step_pos;

   // Result field formatting
   always_comb begin
      op_in    = q_cmd.op;
      char_in  = '0;
      dcol_in  = '0;
      drow_in  = '0;
      acol_in  = '0;
      arow_in  = '0;
      attrs_in = '0;
      unique case (q_cmd.op)
         OP_PUT_CHAR: char_in = q_cmd.char_code;
         OP_MOVE_REL: begin
            unique case (q_cmd.dir)
               DIR_UP:    drow_in = step_neg;
               DIR_DOWN:  drow_in = step_pos;
               DIR_RIGHT: dcol_in = step_pos;
               DIR_LEFT:  dcol_in = step_neg;
               default:   dcol_in = '0;
            endcase
         end
         OP_MOVE_ABS: begin
            // one-based parameters to zero-based target
            arow_in = (q_cmd.p0 == '0) ? '0 : q_cmd.p0 - COORD_BITS'(1);
            acol_in = (q_cmd.p1 == '0) ? '0 : q_cmd.p1 - COORD_BITS'(1);
         end
         OP_SET_ATTR: attrs_in = q_cmd.attrs;
         default: char_in = '0;
      endcase
   end

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff    <= op_in;
         char_ff  <= char_in;
         dcol_ff  <= dcol_in;
         drow_ff  <= drow_in;
         acol_ff  <= acol_in;
         arow_ff  <= arow_in;
         attrs_ff <= attrs_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.op          = op_ff;
   assign rsp_chan.char_code   = char_ff;
   assign rsp_chan.delta_col   = dcol_ff;
   assign rsp_chan.delta_row   = drow_ff;
   assign rsp_chan.abs_col     = acol_ff;
   assign rsp_chan.abs_row     = arow_ff;
   assign rsp_chan.style_flags = attrs_ff.flags;
   assign rsp_chan.fg_color    = attrs_ff.fg;
   assign rsp_chan.bg_color    = attrs_ff.bg;

endmodule

`default_nettype wire
